/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the hashed integer set.
// Define NO_ASSERTIONS to compile every use down to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property at every rising edge, skipped while reset is asserted.
`define HIS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hashed_integer_set: assertion failed");

// Check a property at every rising edge, reset included.
`define HIS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("hashed_integer_set: assertion failed");

`else

`define HIS_ASSERT(label, clk, rst_n, prop)

`define HIS_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

/* rtl/his_pkg.sv */
// Package for the hashed integer set: field widths, action and status codes.
// No dependencies; the interfaces and the top level import it.
`timescale 1ns / 1ps
`default_nettype none

package his_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned ACT_W = 2;

  typedef logic [ACT_W-1:0] act_t;
  typedef logic [KEY_W-1:0] key_t;

  localparam act_t ACT_CONTAINS = 2'd0;
  localparam act_t ACT_INSERT   = 2'd1;
  localparam act_t ACT_ERASE    = 2'd2;
  localparam act_t ACT_CLEAR    = 2'd3;

  localparam logic ST_DONE = 1'b0;
  localparam logic ST_FULL = 1'b1;

endpackage

`default_nettype wire

/* rtl/his_if.sv */
// Valid/ready channel interfaces for the hashed integer set: request and result words.
// Depends on his_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

interface his_in_if import his_pkg::*; ();
  logic                    valid;
  logic                    ready;
  act_t                    action;
  logic signed [KEY_W-1:0] key;

  modport source(output valid, output action, output key, input ready);
  modport sink(input valid, input action, input key, output ready);
endinterface

interface his_out_if import his_pkg::*; ();
  logic valid;
  logic ready;
  logic was_member;
  logic status;

  modport source(output valid, output was_member, output status, input ready);
  modport sink(input valid, input was_member, input status, output ready);
endinterface

`default_nettype wire

/* rtl/hashed_integer_set.sv */
// Hashed integer set: signed 32-bit keys in BUCKET_COUNT rows of SLOTS_PER_BUCKET slots.
// Uses his_pkg, his_in_if / his_out_if and assert_macros.svh.
// Path from accept to result: bucket read and update for a power-of-two BUCKET_COUNT, else the modulo
// pipeline (S_MUL, S_QN, S_FIX) first; one word in flight, and a stalled output holds it in S_UPD.
// A clear-all action adds a sweep over all BUCKET_COUNT rows of the valid memory.
// Reset (rst_n low, synchronous) starts the same sweep; no word is taken until it ends.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module hashed_integer_set import his_pkg::*; #(
  parameter int unsigned BUCKET_COUNT     = 8,
  parameter int unsigned SLOTS_PER_BUCKET = 4
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  his_in_if.sink     in_ch,
  his_out_if.source  out_ch
);

  // ---------------------------------------------------------------------------
  // Derived constants
  // ---------------------------------------------------------------------------
  localparam int unsigned NB    = BUCKET_COUNT;
  localparam int unsigned SLOTS = SLOTS_PER_BUCKET;
  localparam int unsigned ROW_W = SLOTS * KEY_W;
  // Row address width; a single bucket still gets one address bit.
  localparam int unsigned BW    = (NB > 1) ? $clog2(NB) : 1;
  // Width that holds 0..NB, and one more bit for values below 2*NB.
  localparam int unsigned NW    = $clog2(NB + 1);
  localparam int unsigned RW    = NW + 1;
  // Folded key: hi16 * (2^16 mod NB) + lo16 stays below 2^27.
  localparam int unsigned XW    = 27;
  localparam int unsigned MW    = 32;
  localparam int unsigned PW    = XW + MW;

  localparam longint unsigned NB_L   = longint'(NB);
  localparam longint unsigned C16_L  = 64'h0001_0000 % NB_L;
  localparam longint unsigned D31_L  = 64'h8000_0000 % NB_L;
  localparam longint unsigned RECP_L = 64'h8000_0000 / NB_L;

  localparam logic [NW-1:0] C16_C  = NW'(C16_L);
  localparam logic [RW-1:0] D31_C  = RW'(D31_L);
  localparam logic [RW-1:0] NB_C   = RW'(NB_L);
  localparam logic [MW-1:0] RECP_C = MW'(RECP_L);
  localparam logic [BW-1:0] BKT_LAST = BW'(NB - 1);
  localparam bit            IS_POW2  = ((NB & (NB - 1)) == 0);

  // Sequencer codes
  localparam logic [2:0] S_CLR  = 3'd0;  // sweep valid memory
  localparam logic [2:0] S_IDLE = 3'd1;  // wait for a request word
  localparam logic [2:0] S_MUL  = 3'd2;  // quotient estimate
  localparam logic [2:0] S_QN   = 3'd3;  // quotient times bucket count
  localparam logic [2:0] S_FIX  = 3'd4;  // remainder correction, floored offset
  localparam logic [2:0] S_RD   = 3'd5;  // read bucket row
  localparam logic [2:0] S_UPD  = 3'd6;  // compare, write back, emit result

  // ---------------------------------------------------------------------------
  // Storage: one row per bucket. Keys are undefined until written; each slot's
  // key is only looked at while its valid bit is set.
  // ---------------------------------------------------------------------------
  logic [ROW_W-1:0] key_mem   [NB];
  logic [SLOTS-1:0] valid_mem [NB];

  logic [2:0]       state_r, state_nxt;
  logic [BW-1:0]    clr_cnt_r, clr_cnt_nxt;
  act_t             act_r;
  key_t             key_r;
  logic [BW-1:0]    bkt_r;
  logic [XW-1:0]    h_x_r;
  logic [XW-1:0]    h_q_r;
  logic [XW-1:0]    h_qn_r;
  logic [ROW_W-1:0] rd_keys_r;
  logic [SLOTS-1:0] rd_valid_r;
  logic             out_valid_r;
  logic             out_was_r;
  logic             out_status_r;

  logic             in_take;
  logic             out_free;
  logic             upd_go;
  key_t             in_key_u;
  logic [XW-1:0]    fold_x;
  logic [BW-1:0]    bkt_pow2;
  logic [PW-1:0]    prod;
  logic [RW-1:0]    rem_raw;
  logic [RW-1:0]    rem_fix;
  logic [RW-1:0]    rem_flr;

  logic [SLOTS-1:0] hit_vec;
  logic [SLOTS-1:0] free_vec;
  logic [SLOTS-1:0] free_oh;
  logic [ROW_W-1:0] new_keys;
  logic             was_hit;
  logic             row_full;
  logic             key_we;
  logic             vld_we;
  logic [BW-1:0]    vld_addr;
  logic [SLOTS-1:0] vld_data;
  logic             res_status;

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  assign in_ch.ready       = (state_r == S_IDLE);
  assign in_take           = in_ch.valid && in_ch.ready;
  assign out_free          = !out_valid_r || out_ch.ready;
  assign upd_go            = (state_r == S_UPD) && out_free;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.was_member = out_was_r;
  assign out_ch.status     = out_status_r;

  // ---------------------------------------------------------------------------
  // Bucket hash: floored key mod NB.
  // Offset the key by 2^31 to get an unsigned value u, fold u to 27 bits with
  // 2^16 mod NB, reduce it with a reciprocal multiply and one correction, then
  // take back the offset (2^31 mod NB). A power-of-two count uses the low bits.
  // ---------------------------------------------------------------------------
  assign in_key_u = $unsigned(in_ch.key) ^ {1'b1, {(KEY_W-1){1'b0}}};
  assign fold_x   = XW'(in_key_u[KEY_W-1:16]) * XW'(C16_C) + XW'(in_key_u[15:0]);
  assign bkt_pow2 = BW'($unsigned(in_ch.key)) & BKT_LAST;
  assign prod     = PW'(h_x_r) * PW'(RECP_C);

  always_comb begin
    rem_raw = RW'(h_x_r - h_qn_r);
    // The quotient estimate is at most one low, so one subtract settles it.
    rem_fix = (rem_raw >= NB_C) ? (rem_raw - NB_C) : rem_raw;
    rem_flr = (rem_fix >= D31_C) ? (rem_fix - D31_C) : (rem_fix + NB_C - D31_C);
  end

  // ---------------------------------------------------------------------------
  // Row compare and update
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      hit_vec[s] = rd_valid_r[s] && (rd_keys_r[s*KEY_W +: KEY_W] == key_r);
    end
    free_vec = ~rd_valid_r;
    // Lowest free slot, one-hot.
    free_oh  = free_vec & (~free_vec + SLOTS'(1));
    for (int s = 0; s < SLOTS; s++) begin
      new_keys[s*KEY_W +: KEY_W] = free_oh[s] ? key_r : rd_keys_r[s*KEY_W +: KEY_W];
    end
    was_hit  = |hit_vec;
    row_full = ~|free_vec;
  end

  always_comb begin
    key_we     = 1'b0;
    vld_we     = 1'b0;
    vld_addr   = bkt_r;
    vld_data   = rd_valid_r;
    res_status = ST_DONE;
    if (state_r == S_CLR) begin
      vld_we   = 1'b1;
      vld_addr = clr_cnt_r;
      vld_data = '0;
    end else if (upd_go) begin
      case (act_r)
        ACT_INSERT: begin
          if (!was_hit) begin
            if (row_full) begin
              res_status = ST_FULL;
            end else begin
              key_we   = 1'b1;
              vld_we   = 1'b1;
              vld_data = rd_valid_r | free_oh;
            end
          end
        end
        ACT_ERASE: begin
          if (was_hit) begin
            vld_we   = 1'b1;
            vld_data = rd_valid_r & ~hit_vec;
          end
        end
        // Contains only looks; clear-all is done by the sweep that follows.
        ACT_CONTAINS: ;
        ACT_CLEAR:    ;
        default:      ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      S_CLR: begin
        clr_cnt_nxt = clr_cnt_r + BW'(1);
        if (clr_cnt_r == BKT_LAST) begin
          clr_cnt_nxt = '0;
          state_nxt   = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_take) begin
          state_nxt = IS_POW2 ? S_RD : S_MUL;
        end
      end
      S_MUL: state_nxt = S_QN;
      S_QN:  state_nxt = S_FIX;
      S_FIX: state_nxt = S_RD;
      S_RD:  state_nxt = S_UPD;
      S_UPD: begin
        // Hold here until the result register can take the word.
        if (out_free) begin
          state_nxt   = (act_r == ACT_CLEAR) ? S_CLR : S_IDLE;
          clr_cnt_nxt = '0;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (upd_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: request, hash pipeline, result.
  always_ff @(posedge clk) begin
    if (in_take) begin
      act_r <= in_ch.action;
      key_r <= $unsigned(in_ch.key);
      h_x_r <= fold_x;
      bkt_r <= bkt_pow2;
    end
    if (state_r == S_MUL) begin
      h_q_r <= XW'(prod >> (MW - 1));
    end
    if (state_r == S_QN) begin
      h_qn_r <= XW'(h_q_r * XW'(NB_C));
    end
    if (state_r == S_FIX) begin
      bkt_r <= BW'(rem_flr);
    end
    if (upd_go) begin
      out_was_r    <= was_hit;
      out_status_r <= res_status;
    end
  end

  // Bucket memories: one write port each, registered read of the addressed row.
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[bkt_r] <= new_keys;
    end
    if (vld_we) begin
      valid_mem[vld_addr] <= vld_data;
    end
    if (state_r == S_RD) begin
      rd_keys_r  <= key_mem[bkt_r];
      rd_valid_r <= valid_mem[bkt_r];
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `HIS_ASSERT(a_full_not_member, clk, rst_n, out_valid_r |-> !(out_status_r && out_was_r))
  `HIS_ASSERT(a_bucket_range, clk, rst_n, (state_r == S_RD) |-> (bkt_r <= BKT_LAST))
  `HIS_ASSERT(a_sweep_ends, clk, rst_n,
    (state_r == S_CLR && clr_cnt_r == BKT_LAST) |=> (state_r == S_IDLE))

endmodule

`default_nettype wire
